// ----- src/sdre_pkg.sv -----
// ----------------------------------------------------------------------------
// sdre_pkg
// Shared widths, codes and saturation helper for the spring-damper evaluator.
// ----------------------------------------------------------------------------
package sdre_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // stream payload widths
  localparam int IN_DATA_W  = IDX_W + 5 * 32;
  localparam int OUT_DATA_W = 4 * 32;

  // serial divider: numerator covers the exact rate sum, divisor covers mass << FRAC_BITS
  localparam int DIV_NW = 96;
  localparam int DIV_DW = 31 + FRAC_BITS;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int SUM_W  = 96;
  localparam int WIDE_W = 98;
  localparam int MUL_W  = 34;

  localparam logic [1:0] MODE_HOLD    = 2'd0;
  localparam logic [1:0] MODE_SEARCH  = 2'd1;
  localparam logic [1:0] MODE_UNIFORM = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_GAP = 2'd2;

  localparam logic [2:0] REG_MASS   = 3'd0;
  localparam logic [2:0] REG_SPRING = 3'd1;
  localparam logic [2:0] REG_DAMP   = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_QUAD   = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;
  localparam logic [2:0] REG_COUNT  = 3'd6;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_res_t;

  function automatic sat_res_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_res_t r;
    r.sat = !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
    if (!r.sat) begin
      r.val = v[31:0];
    end else if (v[WIDE_W-1]) begin
      r.val = 32'h8000_0000;
    end else begin
      r.val = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ----- src/spring_damper_rate_eval.sv -----
// ----------------------------------------------------------------------------
// spring_damper_rate_eval
// Force table lookup and spring-damper rate evaluation in Q16.16.
// ----------------------------------------------------------------------------
// Input beats carry an op in in_tuser: 0 loads one (time, force) sample into
// the table at sample_index, 1 evaluates rates at (eval_time, position,
// velocity). Load beats give no result. Each evaluate beat gives one output
// beat: position rate, velocity rate, table force, inertial force, status in
// out_tuser.
// The table sits in two synchronous RAMs with a write port and a read port
// each; all lookups go through the one read port, one entry per cycle. When
// the mode is not uniform, an evaluate walks table entries by linear search
// (up to sample_count). The serial divider serves for the segment slope
// outside hold mode, the uniform index in uniform mode and the mass. One item
// is in work at a time; in_tready is high only while the sequencer is idle.
// The result sits in an output register, so a stalled receiver only blocks
// the sequencer once a second result is ready. Reset clears control state and
// loads register defaults; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module spring_damper_rate_eval
  import sdre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_index, sample_time, sample_force, eval_time, position, velocity
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // position_rate, velocity_rate, interpolated_force, inertial_force
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]            out_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_L0   = 5'd1;
  localparam logic [4:0] S_L1   = 5'd2;
  localparam logic [4:0] S_L2   = 5'd3;
  localparam logic [4:0] S_SRCH = 5'd4;
  localparam logic [4:0] S_U0   = 5'd5;
  localparam logic [4:0] S_UW   = 5'd6;
  localparam logic [4:0] S_SEG0 = 5'd7;
  localparam logic [4:0] S_SEG1 = 5'd8;
  localparam logic [4:0] S_SEG2 = 5'd9;
  localparam logic [4:0] S_SEGM = 5'd10;
  localparam logic [4:0] S_SEGD = 5'd11;
  localparam logic [4:0] S_SEGW = 5'd12;
  localparam logic [4:0] S_M0   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_M3   = 5'd16;
  localparam logic [4:0] S_M4   = 5'd17;
  localparam logic [4:0] S_M5   = 5'd18;
  localparam logic [4:0] S_M6   = 5'd19;
  localparam logic [4:0] S_M7   = 5'd20;
  localparam logic [4:0] S_DW   = 5'd21;
  localparam logic [4:0] S_IN0  = 5'd22;
  localparam logic [4:0] S_IN1  = 5'd23;

  // configuration
  logic [30:0]       mass_r;
  logic signed [31:0] spring_r, damp_r, gain_r, quad_r;
  logic [1:0]        mode_r;
  logic [CNT_W-1:0]  count_r;
  logic              cfg_wr;
  logic [30:0]       m_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic [IDX_W-1:0]  last;

  // table memories
  logic [31:0] time_mem  [TABLE_DEPTH];
  logic [31:0] force_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] t_q_r, f_q_r;

  // sequencer and datapath
  logic [4:0]         state_r, state_nxt;
  logic               in_acc, eval_acc;
  logic signed [31:0] t_r, x_r, v_r, t0_r, f0_r, tl_r, fl_r, force_r, rate_r;
  logic [IDX_W-1:0]   n_r;
  logic               gap0_r, sat_r, neg_r;
  logic [32:0]        dd_mag_r, dt_mag_r, gap_mag_r;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p_r;
  logic signed [SUM_W-1:0]   acc_r, acc_mag, zmag;
  logic [31:0]        vvh_r;
  logic [63:0]        zlo_r;
  logic [31:0]        v_mag, z_mag;
  logic signed [32:0] dd, dt, gap, ut, ug;
  logic               out_free;

  // divider
  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;
  logic signed [WIDE_W-1:0] q_s, seg_sum, rate_w, inert_w;
  logic [2*MUL_W-1:0] p_mag;
  sat_res_t seg_res, rate_res, inert_res;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r   <= 31'd1997537;
      spring_r <= -32'sd3276800;
      damp_r   <= -32'sd655360;
      gain_r   <= 32'sd65536;
      quad_r   <= '0;
      mode_r   <= MODE_SEARCH;
      count_r  <= CNT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MASS:   mass_r   <= pwdata[30:0];
        REG_SPRING: spring_r <= pwdata;
        REG_DAMP:   damp_r   <= pwdata;
        REG_GAIN:   gain_r   <= pwdata;
        REG_QUAD:   quad_r   <= pwdata;
        REG_MODE:   mode_r   <= pwdata[1:0];
        REG_COUNT:  count_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MASS:   prdata = {1'b0, mass_r};
      REG_SPRING: prdata = spring_r;
      REG_DAMP:   prdata = damp_r;
      REG_GAIN:   prdata = gain_r;
      REG_QUAD:   prdata = quad_r;
      REG_MODE:   prdata = {30'd0, mode_r};
      REG_COUNT:  prdata = {{(32-CNT_W){1'b0}}, count_r};
      default:    prdata = '0;
    endcase
  end

  assign m_eff = (mass_r == '0) ? 31'd1 : mass_r;

  always_comb begin
    priority if (count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (count_r > CNT_W'(TABLE_DEPTH)) begin
      cnt_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      cnt_eff = count_r;
    end
  end
  assign last = IDX_W'(cnt_eff - 1'b1);

  // ---------------- handshake ----------------
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign eval_acc  = in_acc && in_tuser;
  assign out_free  = !out_tvalid || out_tready;

  // ---------------- table RAMs ----------------
  always_ff @(posedge clk) begin
    if (in_acc && !in_tuser) begin
      time_mem[in_tdata[IDX_W-1:0]]  <= in_tdata[IDX_W+31:IDX_W];
      force_mem[in_tdata[IDX_W-1:0]] <= in_tdata[IDX_W+63:IDX_W+32];
    end
    t_q_r <= time_mem[rd_addr];
    f_q_r <= force_mem[rd_addr];
  end

  always_comb begin
    unique case (state_r)
      S_L1:    rd_addr = last;
      S_L2:    rd_addr = IDX_W'(1);
      S_SRCH:  rd_addr = n_r + 1'b1;  // fetch ahead while checking n_r
      S_SEG0:  rd_addr = n_r - 1'b1;
      S_SEG1:  rd_addr = n_r;
      default: rd_addr = '0;
    endcase
  end

  // ---------------- segment and index arithmetic ----------------
  assign dd  = 33'(f_q_r) - 33'(fl_r);
  assign dt  = 33'(t_r) - 33'(tl_r);
  assign gap = 33'(t_q_r) - 33'(tl_r);
  assign ut  = 33'(t_r) - 33'(t0_r);
  assign ug  = 33'(t_q_r) - 33'(t0_r);

  assign v_mag = v_r[31] ? 32'(-33'(v_r)) : v_r;
  assign z_mag = quad_r[31] ? 32'(-33'(quad_r)) : quad_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M0:  begin mul_a = MUL_W'(spring_r); mul_b = MUL_W'(x_r); end
      S_M1:  begin mul_a = MUL_W'(damp_r);   mul_b = MUL_W'(v_r); end
      S_M2:  begin mul_a = MUL_W'(gain_r);   mul_b = MUL_W'(force_r); end
      S_M3:  begin mul_a = {2'b0, v_mag};    mul_b = {2'b0, v_mag}; end
      S_M4:  begin mul_a = {2'b0, z_mag};    mul_b = {2'b0, mul_p_r[31:0]}; end
      S_M5:  begin mul_a = {2'b0, z_mag};    mul_b = {2'b0, vvh_r}; end
      S_SEGM: begin mul_a = {1'b0, dd_mag_r}; mul_b = {1'b0, dt_mag_r}; end
      // held through the output wait so the inertial product stays valid
      S_IN0, S_IN1: begin mul_a = {3'b0, m_eff}; mul_b = MUL_W'(rate_r); end
      default: ;
    endcase
  end

  assign zmag    = {mul_p_r[63:0], 32'd0} + SUM_W'(zlo_r);
  assign acc_mag = acc_r[SUM_W-1] ? -acc_r : acc_r;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_U0: begin
        div_start = (ug != '0);
        div_num   = DIV_NW'(ut[32] ? 33'(-ut) : ut);
        div_den   = DIV_DW'(ug[32] ? 33'(-ug) : ug);
      end
      S_SEGD: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(mul_p_r[64:0]);
        div_den   = DIV_DW'(gap_mag_r);
      end
      S_M7: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(acc_mag);
        div_den   = {m_eff, {FRAC_BITS{1'b0}}};
      end
      default: ;
    endcase
  end

  sdre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_s       = {2'b00, div_quot};
  assign seg_sum   = WIDE_W'(fl_r) + (neg_r ? -q_s : q_s);
  assign seg_res   = sat32(seg_sum);
  assign rate_w    = neg_r ? -q_s : q_s;
  assign rate_res  = sat32(rate_w);
  assign p_mag     = mul_p_r[2*MUL_W-1] ? (2*MUL_W)'(-mul_p_r) : mul_p_r;
  assign inert_w   = mul_p_r[2*MUL_W-1] ? -WIDE_W'(p_mag >> FRAC_BITS)
                                        : WIDE_W'(p_mag >> FRAC_BITS);
  assign inert_res = sat32(inert_w);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (eval_acc) state_nxt = S_L0;
      S_L0:   state_nxt = S_L1;
      S_L1:   state_nxt = (t_r <= t_q_r) ? S_M0 : S_L2;
      S_L2: begin
        priority if (t_q_r <= t_r) begin
          state_nxt = S_M0;
        end else if (mode_r == MODE_UNIFORM) begin
          state_nxt = S_U0;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: if (t_q_r >= t_r) state_nxt = S_SEG0;
      S_U0:   state_nxt = (ug == '0) ? S_M0 : S_UW;
      S_UW:   if (div_done) state_nxt = S_SEG0;
      S_SEG0: state_nxt = S_SEG1;
      S_SEG1: state_nxt = (mode_r == MODE_HOLD) ? S_M0 : S_SEG2;
      S_SEG2: state_nxt = (gap == '0) ? S_M0 : S_SEGM;
      S_SEGM: state_nxt = S_SEGD;
      S_SEGD: state_nxt = S_SEGW;
      S_SEGW: if (div_done) state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_M7;
      S_M7:   state_nxt = S_DW;
      S_DW:   if (div_done) state_nxt = S_IN0;
      S_IN0:  state_nxt = S_IN1;
      S_IN1:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        if (eval_acc) begin
          t_r    <= in_tdata[IDX_W+95:IDX_W+64];
          x_r    <= in_tdata[IDX_W+127:IDX_W+96];
          v_r    <= in_tdata[IDX_W+159:IDX_W+128];
          gap0_r <= 1'b0;
          sat_r  <= 1'b0;
        end
      end
      S_L1: begin
        t0_r    <= t_q_r;
        f0_r    <= f_q_r;
        force_r <= f_q_r;
      end
      S_L2: begin
        force_r <= f_q_r;
        n_r     <= IDX_W'(1);
      end
      S_SRCH: if (t_q_r < t_r) n_r <= n_r + 1'b1;
      S_U0: begin
        neg_r <= ug[32];
        if (ug == '0) begin
          gap0_r  <= 1'b1;
          force_r <= f0_r;
        end
      end
      S_UW: begin
        // index = quotient + 1, held inside 1 .. count-1
        if (neg_r || div_quot < DIV_NW'(last)) begin
          n_r <= neg_r ? IDX_W'(1) : IDX_W'(div_quot) + 1'b1;
        end else begin
          n_r <= last;
        end
      end
      S_SEG1: begin
        tl_r    <= t_q_r;
        fl_r    <= f_q_r;
        force_r <= f_q_r;
      end
      S_SEG2: begin
        dd_mag_r  <= dd[32] ? 33'(-dd) : dd;
        dt_mag_r  <= dt[32] ? 33'(-dt) : dt;
        gap_mag_r <= gap[32] ? 33'(-gap) : gap;
        neg_r     <= dd[32] ^ dt[32] ^ gap[32];
        if (gap == '0) gap0_r <= 1'b1;
      end
      S_SEGW: begin
        if (div_done) begin
          force_r <= seg_res.val;
          if (seg_res.sat) sat_r <= 1'b1;
        end
      end
      S_M1: acc_r <= SUM_W'(mul_p_r) <<< FRAC_BITS;
      S_M2: acc_r <= acc_r + (SUM_W'(mul_p_r) <<< FRAC_BITS);
      S_M3: acc_r <= acc_r + (SUM_W'(mul_p_r) <<< FRAC_BITS);
      S_M4: vvh_r <= mul_p_r[63:32];
      S_M5: zlo_r <= mul_p_r[63:0];
      S_M6: acc_r <= quad_r[31] ? acc_r - zmag : acc_r + zmag;
      S_M7: neg_r <= acc_r[SUM_W-1];
      S_DW: begin
        if (div_done) begin
          rate_r <= rate_res.val;
          if (rate_res.sat) sat_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;
  logic                  out_valid_r;
  logic                  out_load;

  assign out_load = (state_r == S_IN1) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {inert_res.val, force_r, rate_r, v_r};
      priority if (gap0_r) begin
        out_user_r <= ST_GAP;
      end else if (sat_r || inert_res.sat) begin
        out_user_r <= ST_SAT;
      end else begin
        out_user_r <= ST_OK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_busy_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    eval_acc |=> !in_tready)
    else $error("input taken again right after an evaluate beat");

  a_seg_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEG0) |-> (n_r != '0 && n_r <= last))
    else $error("segment index outside 1 .. count-1");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEGW || state_r == S_DW || state_r == S_UW) && !div_done |-> div_busy)
    else $error("waiting on an idle divider");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_user_r != 2'd3))
    else $error("undefined status code");

endmodule

// ----- src/sdre_div.sv -----
// ----------------------------------------------------------------------------
// sdre_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdre_div
  import sdre_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] quo_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_DW'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule
